// File: rtl/fuz_pkg.sv
// Shared constants, types and codes for the fuzzy t-norm unit.
package fuz_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned GradeW   = 17;
  localparam int unsigned ParamW   = 8;
  localparam int unsigned DenW     = FracBits + ParamW;
  localparam int unsigned QuotW    = FracBits + 1;
  localparam int unsigned ProdW    = 2 * GradeW;
  localparam int unsigned SumW     = GradeW + 1;
  // accept edge to result-accepted edge: 3 front stages, queue slot, stage 0, divider steps
  localparam int unsigned PipeLatency = 5 + QuotW;

  localparam logic [GradeW-1:0] One = GradeW'(1) << FracBits;

  localparam logic [ParamW-1:0] HamParamRst    = ParamW'(100);
  localparam logic [GradeW-1:0] DrasticThrRst  = GradeW'(64880);

  typedef enum logic [2:0] {
    KIND_MIN      = 3'd0,
    KIND_PROD     = 3'd1,
    KIND_DRASTIC  = 3'd2,
    KIND_LUK      = 3'd3,
    KIND_HAMACHER = 3'd4
  } kind_e;

  typedef enum logic {
    CFG_HAM_PARAM   = 1'b0,
    CFG_DRASTIC_THR = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ParamW-1:0] ham_param;
    logic [GradeW-1:0] drastic_thr;
  } cfg_t;

  // One classified item: either a finished value or a Hamacher quotient t/d
  typedef struct packed {
    logic              is_ham;
    logic [GradeW-1:0] value;
    logic [GradeW-1:0] t;
    logic [DenW-1:0]   d;
  } item_t;

endpackage

// File: rtl/fuzzy_tnorm_unit.sv
// Top level of the fuzzy t-norm unit: config registers, front, queue, back.
//
// Takes one grade pair per clock: start is accepted whenever busy is low, and
// busy stays low, so a new transfer may follow in every cycle. Each transfer
// yields exactly one result (done_o high for one cycle with norm_value_o);
// results leave in order and the receiver cannot stall them. The path runs
// through three front stages (saturate, 17x17 product, Hamacher denominator
// multiply), one queue slot, and a 17-step pipelined restoring divider that
// forms the Hamacher quotient one bit per stage; the other norms ride along
// that pipeline so latency is the same for all kinds. Grades above 1.0
// (65536) are saturated; kinds 5..7 return 0. Write the configuration
// registers only while no transfer is in flight.
module fuzzy_tnorm_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 kind_i,
  input  logic [fuz_pkg::GradeW-1:0] grade_a_i,
  input  logic [fuz_pkg::GradeW-1:0] grade_b_i,
  output logic                       done_o,
  output logic [fuz_pkg::GradeW-1:0] norm_value_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [fuz_pkg::GradeW-1:0] cfg_data_i
);
  import fuz_pkg::*;

  cfg_t  cfg_q;
  logic  push, pop;
  item_t fr_item, q_item;

  // fully pipelined, never holds off a transfer
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ham_param   <= HamParamRst;
      cfg_q.drastic_thr <= DrasticThrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HAM_PARAM:   cfg_q.ham_param   <= cfg_data_i[ParamW-1:0];
        CFG_DRASTIC_THR: cfg_q.drastic_thr <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fuz_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (start && !busy),
    .kind_i    (kind_i),
    .grade_a_i (grade_a_i),
    .grade_b_i (grade_b_i),
    .cfg_i     (cfg_q),
    .push_o    (push),
    .item_o    (fr_item)
  );

  fuz_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (fr_item),
    .pop_o  (pop),
    .item_o (q_item)
  );

  fuz_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_i        (pop),
    .item_i       (q_item),
    .done_o       (done_o),
    .norm_value_o (norm_value_o)
  );

endmodule

// File: rtl/fuz_front.sv
// Front end: input capture, saturation, simple norms and Hamacher operands.
module fuz_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       take_i,
  input  logic [2:0]                 kind_i,
  input  logic [fuz_pkg::GradeW-1:0] grade_a_i,
  input  logic [fuz_pkg::GradeW-1:0] grade_b_i,
  input  fuz_pkg::cfg_t              cfg_i,
  output logic                       push_o,
  output fuz_pkg::item_t             item_o
);
  import fuz_pkg::*;

  // stage A
  logic              va_q;
  logic [2:0]        kind_q;
  logic [GradeW-1:0] a_q, b_q;
  // stage B
  logic              vb_q, hamb_q;
  logic [GradeW-1:0] t_q, val_q;
  logic [SumW-1:0]   sum_q;
  // stage C
  logic              vc_q;
  item_t             item_q;

  logic [ProdW-1:0]  prod;
  logic [GradeW-1:0] mn, luk, val_d, s, om;
  logic [SumW-1:0]   sum, s_raw;
  logic              ham_d;

  always_comb begin
    prod  = ProdW'(a_q) * ProdW'(b_q);
    mn    = (a_q < b_q) ? a_q : b_q;
    sum   = SumW'(a_q) + SumW'(b_q);
    luk   = (sum > SumW'(One)) ? GradeW'(sum - SumW'(One)) : '0;
    ham_d = 1'b0;
    case (kind_e'(kind_q))
      KIND_MIN:      val_d = mn;
      KIND_PROD:     val_d = prod[FracBits +: GradeW];
      KIND_DRASTIC: begin
        val_d = ((a_q > cfg_i.drastic_thr) || (b_q > cfg_i.drastic_thr)) ? mn : '0;
      end
      KIND_LUK:      val_d = luk;
      KIND_HAMACHER: begin
        val_d = '0;
        ham_d = (a_q != '0) || (b_q != '0); // both zero gives 0
      end
      default:       val_d = '0;
    endcase
  end

  always_comb begin
    s_raw = sum_q - SumW'(t_q);
    s     = (s_raw > SumW'(One)) ? One : s_raw[GradeW-1:0];
    om    = One - s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= take_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_i;
    a_q    <= (grade_a_i > One) ? One : grade_a_i;
    b_q    <= (grade_b_i > One) ? One : grade_b_i;
    t_q    <= prod[FracBits +: GradeW];
    sum_q  <= sum;
    val_q  <= val_d;
    hamb_q <= ham_d;
    item_q.is_ham <= hamb_q;
    item_q.value  <= val_q;
    item_q.t      <= t_q;
    item_q.d      <= DenW'(DenW'(cfg_i.ham_param) * DenW'(om)) + DenW'(s);
  end

  assign push_o = vc_q;
  assign item_o = item_q;

endmodule

// File: rtl/fuz_queue.sv
// Two-entry queue between front and back.
module fuz_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fuz_pkg::item_t item_i,
  output logic           pop_o,
  output fuz_pkg::item_t item_o
);
  import fuz_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign pop_o  = (cnt_q != 2'd0);
  assign item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_o)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// File: rtl/fuz_back.sv
// Back end: pipelined restoring divider for Hamacher, pass-through otherwise.
module fuz_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_i,
  input  fuz_pkg::item_t             item_i,
  output logic                       done_o,
  output logic [fuz_pkg::GradeW-1:0] norm_value_o
);
  import fuz_pkg::*;

  logic              v_q   [QuotW+1];
  logic              ham_q [QuotW+1];
  logic [GradeW-1:0] val_q [QuotW+1];
  logic [DenW-1:0]   r_q   [QuotW+1];
  logic [DenW-1:0]   d_q   [QuotW+1];
  logic [QuotW-1:0]  q_q   [QuotW+1];
  logic              lsb_q;

  logic [DenW:0]     trial [QuotW];
  logic              ge    [QuotW];

  always_comb begin
    for (int k = 0; k < QuotW; k++) begin
      trial[k] = {r_q[k], (k == 0) ? lsb_q : 1'b0};
      ge[k]    = trial[k] >= {1'b0, d_q[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QuotW; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[0] <= pop_i;
      for (int k = 0; k < QuotW; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    // numerator is t << FracBits; quotient fits QuotW bits, so start at t >> 1
    ham_q[0] <= item_i.is_ham;
    val_q[0] <= item_i.value;
    r_q[0]   <= DenW'(item_i.t >> 1);
    lsb_q    <= item_i.t[0];
    d_q[0]   <= item_i.d;
    q_q[0]   <= '0;
    for (int k = 0; k < QuotW; k++) begin
      ham_q[k+1] <= ham_q[k];
      val_q[k+1] <= val_q[k];
      d_q[k+1]   <= d_q[k];
      r_q[k+1]   <= ge[k] ? DenW'(trial[k] - {1'b0, d_q[k]}) : trial[k][DenW-1:0];
      q_q[k+1]   <= {q_q[k][QuotW-2:0], ge[k]};
    end
  end

  assign done_o       = v_q[QuotW];
  assign norm_value_o = ham_q[QuotW] ? GradeW'(q_q[QuotW]) : val_q[QuotW];

endmodule

// File: rtl/fuzzy_tnorm_unit_chk.sv
// Port-level checker for the fuzzy t-norm unit, bound to the top level.
module fuzzy_tnorm_unit_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic [2:0]                 kind_i,
  input logic                       done_o,
  input logic [fuz_pkg::GradeW-1:0] norm_value_o
);
  import fuz_pkg::*;

  // every transfer gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PipeLatency done_o)
    else $error("missing result");

  // no result without a transfer that caused it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PipeLatency))
    else $error("spurious result");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (norm_value_o <= One))
    else $error("norm above one");

  a_bad_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(kind_i, PipeLatency) == 3'd5 || $past(kind_i, PipeLatency) == 3'd6
      || $past(kind_i, PipeLatency) == 3'd7)) |-> (norm_value_o == '0))
    else $error("bad kind gave nonzero");

endmodule

bind fuzzy_tnorm_unit fuzzy_tnorm_unit_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .kind_i       (kind_i),
  .done_o       (done_o),
  .norm_value_o (norm_value_o)
);

// File: sim/tb_top.sv
// Testbench for the fuzzy t-norm unit: directed and random grade pairs checked against a predictor.
module tb_top;
  import fuz_pkg::*;

  localparam int unsigned NumRandom = 1150;
  localparam longint unsigned CycleLimit = 200000;

  // Scoreboard: in-order store of expected norm values
  class norm_scoreboard;
    logic [GradeW-1:0] pending_norms[$];
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned orphans = 0;

    function void note_transfer(logic [GradeW-1:0] expected_norm);
      pending_norms.push_back(expected_norm);
    endfunction

    function void check_norm(logic [GradeW-1:0] got);
      logic [GradeW-1:0] want;
      if (pending_norms.size() == 0) begin
        orphans++;
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %0d", got);
        return;
      end
      want = pending_norms.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: norm_value expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        kind_i = '0;
  logic [GradeW-1:0] grade_a_i = '0;
  logic [GradeW-1:0] grade_b_i = '0;
  logic              done_o;
  logic [GradeW-1:0] norm_value_o;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = CFG_HAM_PARAM;
  logic [GradeW-1:0] cfg_data_i = '0;

  norm_scoreboard sb = new();
  logic [ParamW-1:0] model_ham_p;
  logic [GradeW-1:0] model_thr;
  longint unsigned cycle_count = 0;
  int unsigned kind_seen[8];

  fuzzy_tnorm_unit dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .grade_a_i, .grade_b_i,
    .done_o, .norm_value_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Results can't be held off: check every strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_norm(norm_value_o);
  end

  // Predicted t-norm for one grade pair under the current model config
  function automatic logic [GradeW-1:0] predict_norm(logic [2:0] k, logic [GradeW-1:0] ga,
                                                     logic [GradeW-1:0] gb);
    logic [63:0] a, b, one, t, s, d, r;
    one = 64'd1 << FracBits;
    a = (ga > one) ? one : 64'(ga);
    b = (gb > one) ? one : 64'(gb);
    case (k)
      KIND_MIN:     r = (a > b) ? b : a;
      KIND_PROD:    r = (a * b) >> FracBits;
      KIND_DRASTIC: r = (a > model_thr || b > model_thr) ? ((a > b) ? b : a) : 64'd0;
      KIND_LUK:     r = (a + b > one) ? a + b - one : 64'd0;
      KIND_HAMACHER: begin
        if (a == 0 && b == 0) r = 0;
        else begin
          t = (a * b) >> FracBits;
          s = a + b - t;
          if (s > one) s = one;
          d = 64'(model_ham_p) * (one - s) + s;
          r = (d == 0) ? 64'd0 : (t << FracBits) / d;
        end
      end
      default: r = 0;
    endcase
    return r[GradeW-1:0];
  endfunction

  task automatic write_cfg(cfg_idx_e idx, logic [GradeW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_HAM_PARAM) model_ham_p = value[ParamW-1:0];
    else model_thr = value;
  endtask

  // One transfer; start stays high across back-to-back calls
  task automatic send_pair(logic [2:0] k, logic [GradeW-1:0] ga, logic [GradeW-1:0] gb);
    start     <= 1'b1;
    kind_i    <= k;
    grade_a_i <= ga;
    grade_b_i <= gb;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_transfer(predict_norm(k, ga, gb));
    kind_seen[k]++;
  endtask

  task automatic pause_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drain in-flight work before touching config
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_norms.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random grade biased toward edges; full 17-bit range incl. above-one values
  function automatic logic [GradeW-1:0] rand_grade();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return One;
      2: return GradeW'($urandom_range(65536 - 300, 65536));
      3: return GradeW'($urandom_range(65537, 131071));
      4: return GradeW'($urandom_range(0, 300));
      default: return GradeW'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic random_burst_phase(int unsigned n);
    int unsigned sent, burst;
    logic [2:0] k;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && sent < n) begin
        k = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_pair(k, rand_grade(), rand_grade());
        burst--;
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_cycles($urandom_range(1, 25));
    end
  endtask

  initial begin
    int unsigned per_phase;
    model_ham_p = HamParamRst;
    model_thr   = DrasticThrRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, every kind, grade extremes, above-one saturation
    send_pair(KIND_MIN, One, 17'h1FFFF);
    send_pair(KIND_MIN, 17'd0, One);
    send_pair(KIND_PROD, One, One);
    send_pair(KIND_PROD, 17'h1FFFF, 17'd12345);
    send_pair(KIND_DRASTIC, 17'd64880, 17'd64880);
    send_pair(KIND_DRASTIC, 17'd64881, 17'd500);
    send_pair(KIND_DRASTIC, 17'd10, One);
    send_pair(KIND_LUK, 17'd32768, 17'd32768);
    send_pair(KIND_LUK, 17'd40000, 17'd40000);
    send_pair(KIND_LUK, 17'h1FFFF, 17'h1FFFF);
    send_pair(KIND_HAMACHER, 17'd0, 17'd0);
    send_pair(KIND_HAMACHER, 17'd0, One);
    send_pair(KIND_HAMACHER, One, One);
    send_pair(KIND_HAMACHER, 17'd1, 17'd1);
    send_pair(KIND_HAMACHER, 17'd30000, 17'd50000);
    send_pair(3'd5, One, One);
    send_pair(3'd6, 17'd100, 17'd200);
    send_pair(3'd7, 17'h1FFFF, 17'h1FFFF);

    // Random phases across config settings, extremes included
    per_phase = NumRandom / 5;
    drain();
    random_burst_phase(per_phase);
    drain();
    write_cfg(CFG_HAM_PARAM, 17'd0);
    write_cfg(CFG_DRASTIC_THR, 17'd0);
    random_burst_phase(per_phase);
    drain();
    write_cfg(CFG_HAM_PARAM, 17'd255);
    write_cfg(CFG_DRASTIC_THR, One);
    random_burst_phase(per_phase);
    drain();
    write_cfg(CFG_HAM_PARAM, 17'd1);
    write_cfg(CFG_DRASTIC_THR, 17'd32768);
    random_burst_phase(per_phase);
    drain();
    write_cfg(CFG_HAM_PARAM, 17'($urandom_range(2, 254)));
    write_cfg(CFG_DRASTIC_THR, 17'($urandom_range(0, 65536)));
    random_burst_phase(per_phase);

    // Final drain with settle time for the pipeline
    start <= 1'b0;
    while (sb.pending_norms.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 5) @(posedge clk_i);

    $display("Checked %0d results over 5 config settings; kinds min/prod/drastic/luk/ham = %0d/%0d/%0d/%0d/%0d",
             sb.checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    $display("Out-of-range kinds: %0d, mismatches: %0d",
             kind_seen[5] + kind_seen[6] + kind_seen[7], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_norms.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
